### rtl/rvad_pkg.sv
package rvad_pkg;

    localparam int MAX_CHUNK_SAMPLES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF       = 2;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int MEAN_W     = 31;
    localparam int RAD_W      = 32;
    localparam int RMS_W      = 16;
    localparam int ROOT_STEPS = 16;
    localparam int SREM_W     = 20;
    localparam int THR_W      = 16;
    localparam int RUN_W      = 4;
    localparam int HIST_W     = 8;
    localparam int SEEN_W     = 3;
    localparam int PREV_W     = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RMS_THRESHOLD     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENT_RUN_LENGTH = 4'd1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd5000;
    localparam logic [RUN_W-1:0] RUN_RESET = 4'd3;
    localparam logic [RUN_W-1:0] RUN_MAX   = 4'd8;

    typedef struct packed {
        logic [THR_W-1:0] rms_threshold;
        logic [RUN_W-1:0] silent_run_length;
    } rvad_cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_FIN
    } bk_state_t;

endpackage

### rtl/rvad_sample_if.sv
interface rvad_sample_if
    import rvad_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_chunk;

    modport source (output valid, output sample, output last_in_chunk, input ready);
    modport sink (input valid, input sample, input last_in_chunk, output ready);
endinterface

### rtl/rvad_result_if.sv
interface rvad_result_if
    import rvad_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] rms_level;
    logic             chunk_loud;
    logic             voice_active;
    logic             chunk_overflow;

    modport source (
        output valid, output rms_level, output chunk_loud, output voice_active,
        output chunk_overflow, input ready
    );
    modport sink (
        input valid, input rms_level, input chunk_loud, input voice_active,
        input chunk_overflow, output ready
    );
endinterface

### rtl/rvad_cfg_if.sv
interface rvad_cfg_if
    import rvad_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rms_voice_activity_detector.sv
// RMS voice activity detector.
// samples: one signed 16-bit sample per transfer; last_in_chunk closes a chunk.
// results: one transfer per chunk with rms_level, chunk_loud, voice_active and
//   chunk_overflow.
// cfg: register writes (index 0 rms_threshold, 1 silent_run_length); always
//   ready, write only while no chunk is in flight.
// Throughput: one sample per cycle within a chunk, unless a closing sample waits
// in the pipeline register for room in the chunk queue. From that register the
// chunk total is pushed into the queue. The back end then loads the chunk, runs
// a bit-serial division of the SUM_W-bit sum (43 bits at 4096 samples) by the
// sample count and a bit-serial square root, and posts the result; it takes no
// new chunk from the queue until it is back in its idle state.
// Reset clears the accumulator, the queue, the loudness history and loads the
// default registers (threshold 5000, run length 3).
// A stalled results channel holds its result; the back end finishes the next
// chunk into its final step and waits; further chunks collect in the queue and
// then samples back-pressure once a closing sample finds the queue full.
module rms_voice_activity_detector
    import rvad_pkg::*;
#(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rvad_sample_if.sink   samples,
    rvad_result_if.source results,
    rvad_cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SUM_W = SQ_W - 1 + CNT_W;
    localparam int Q_W   = SUM_W + CNT_W + 1;

    logic [THR_W-1:0] thr_reg;
    logic [RUN_W-1:0] run_reg;
    rvad_cfg_t        cfg_val;
    logic             push_valid;
    logic             push_ready;
    logic [Q_W-1:0]   push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [Q_W-1:0]   pop_data;

    assign cfg.ready = 1'b1;
    assign cfg_val   = '{rms_threshold: thr_reg, silent_run_length: run_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            run_reg <= RUN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RMS_THRESHOLD:     thr_reg <= cfg.data[THR_W-1:0];
                CFG_SILENT_RUN_LENGTH: run_reg <= cfg.data[RUN_W-1:0];
                default:               ;
            endcase
        end
    end

    rvad_front #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rvad_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rvad_back #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_val),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

`ifndef ASSERT_OFF
    a_full_queue_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |-> !samples.ready)
        else $error("closing sample accepted while chunk queue is full");

    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("back end took two chunks in consecutive cycles");

    a_quiet_implies_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.voice_active) |-> !results.chunk_loud)
        else $error("loud chunk reported as inactive");
`endif

endmodule

### rtl/rvad_front.sv
module rvad_front
    import rvad_pkg::*;
#(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1),
    localparam int SUM_W = SQ_W - 1 + CNT_W
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    rvad_sample_if.sink            samples,
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [SUM_W+CNT_W:0]   push_data
);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  ovf_reg;
    logic                  pipe_valid_reg;
    logic                  pipe_last_reg;
    logic [SQ_W-1:0]       pipe_sq_reg;
    logic [CNT_W-1:0]      pipe_cnt_reg;
    logic                  pipe_ovf_reg;
    logic [SUM_W-1:0]      sum_reg;

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] sq_full;
    logic                  in_fire;
    logic                  full;
    logic                  take;
    logic [CNT_W-1:0]      cnt_upd;
    logic                  ovf_upd;
    logic                  pipe_go;
    logic [SUM_W-1:0]      sum_upd;

    assign mag     = samples.sample[SAMPLE_W-1] ? $unsigned(-samples.sample)
                                                : $unsigned(samples.sample);
    assign sq_full = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
    assign full    = (cnt_reg == CNT_W'(MAX_CHUNK_SAMPLES));
    assign in_fire = samples.valid && samples.ready;
    assign take    = in_fire && !full;
    assign cnt_upd = take ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_upd = ovf_reg || (in_fire && full);

    assign pipe_go       = pipe_valid_reg && !(pipe_last_reg && !push_ready);
    assign samples.ready = !pipe_valid_reg || pipe_go;
    assign sum_upd       = sum_reg + {{(SUM_W-SQ_W){1'b0}}, pipe_sq_reg};
    assign push_valid    = pipe_valid_reg && pipe_last_reg;
    assign push_data     = {sum_upd, pipe_cnt_reg, pipe_ovf_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            pipe_valid_reg <= 1'b0;
            sum_reg        <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                pipe_valid_reg <= 1'b1;
                cnt_reg        <= samples.last_in_chunk ? '0 : cnt_upd;
                ovf_reg        <= samples.last_in_chunk ? 1'b0 : ovf_upd;
            end
            else if (pipe_go)
            begin
                pipe_valid_reg <= 1'b0;
            end
            if (pipe_go)
            begin
                sum_reg <= pipe_last_reg ? '0 : sum_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pipe_last_reg <= samples.last_in_chunk;
            pipe_sq_reg   <= take ? sq_full[SQ_W-1:0] : '0;
            pipe_cnt_reg  <= cnt_upd;
            pipe_ovf_reg  <= ovf_upd;
        end
    end

endmodule

### rtl/rvad_queue.sv
module rvad_queue
    import rvad_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/rvad_back.sv
module rvad_back
    import rvad_pkg::*;
#(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF,
    localparam int CNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1),
    localparam int SUM_W  = SQ_W - 1 + CNT_W,
    localparam int PROD_W = 2 * THR_W + CNT_W,
    localparam int STEP_W = $clog2(SUM_W)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvad_cfg_t            cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [SUM_W+CNT_W:0] pop_data,
    rvad_result_if.source        results
);

    bk_state_t           state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [SREM_W-1:0]   srem_reg, srem_next;
    logic [RMS_W-1:0]    root_reg, root_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [2*THR_W-1:0]  thr2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [HIST_W-1:0]   hist_reg, hist_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic                out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]    out_rms_reg, out_rms_next;
    logic                out_loud_reg, out_loud_next;
    logic                out_active_reg, out_active_next;
    logic                out_ovf_reg, out_ovf_next;

    logic [CNT_W:0]      div_trial;
    logic                div_ge;
    logic [CNT_W:0]      div_diff;
    logic [SREM_W-1:0]   sq_shift;
    logic [SREM_W-1:0]   sq_trial;
    logic                sq_ge;
    logic [SREM_W-1:0]   sq_diff;
    logic                loud;
    logic [RUN_W-1:0]    run_clamp;
    logic [RUN_W-1:0]    prev_full;
    logic [PREV_W-1:0]   prev_needed;
    logic [HIST_W:0]     mask_wide;
    logic [HIST_W-1:0]   prev_mask;
    logic                active;
    logic                out_free;

    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, cnt_reg});
    assign div_diff  = div_trial - {1'b0, cnt_reg};

    assign sq_shift = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial = {{(SREM_W-RMS_W-2){1'b0}}, root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_diff  = sq_shift - sq_trial;

    assign loud = ({{(PROD_W-SUM_W){1'b0}}, sum_reg} >= prod_reg);

    always_comb
    begin
        run_clamp = cfg.silent_run_length;
        if (run_clamp == '0)
        begin
            run_clamp = RUN_W'(1);
        end
        if (run_clamp > RUN_MAX)
        begin
            run_clamp = RUN_MAX;
        end
    end

    assign prev_full   = run_clamp - 1'b1;
    assign prev_needed = prev_full[PREV_W-1:0];
    assign mask_wide   = ({{HIST_W{1'b0}}, 1'b1} << prev_needed) - 1'b1;
    assign prev_mask   = mask_wide[HIST_W-1:0];
    assign active      = loud || (seen_reg < SEEN_W'(prev_needed))
                         || ((hist_reg & prev_mask) != '0);
    assign out_free    = !out_valid_reg || results.ready;

    assign pop_ready              = (state_reg == BK_IDLE);
    assign results.valid          = out_valid_reg;
    assign results.rms_level      = out_rms_reg;
    assign results.chunk_loud     = out_loud_reg;
    assign results.voice_active   = out_active_reg;
    assign results.chunk_overflow = out_ovf_reg;

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        rad_next        = rad_reg;
        srem_next       = srem_reg;
        root_next       = root_reg;
        step_next       = step_reg;
        hist_next       = hist_reg;
        seen_next       = seen_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_rms_next    = out_rms_reg;
        out_loud_next   = out_loud_reg;
        out_active_next = out_active_reg;
        out_ovf_next    = out_ovf_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    sum_next   = pop_data[SUM_W+CNT_W:CNT_W+1];
                    cnt_next   = pop_data[CNT_W:1];
                    ovf_next   = pop_data[0];
                    quo_next   = pop_data[SUM_W+CNT_W:CNT_W+1];
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                quo_next = {quo_reg[SUM_W-2:0], div_ge};
                rem_next = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
                if (step_reg == '0)
                begin
                    rad_next   = {{(RAD_W-MEAN_W){1'b0}}, quo_next[MEAN_W-1:0]};
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(ROOT_STEPS - 1);
                    state_next = BK_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            BK_SQRT:
            begin
                srem_next = sq_ge ? sq_diff : sq_shift;
                root_next = {root_reg[RMS_W-2:0], sq_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    state_next = BK_FIN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            BK_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rms_next    = root_reg;
                    out_loud_next   = loud;
                    out_active_next = active;
                    out_ovf_next    = ovf_reg;
                    hist_next       = {hist_reg[HIST_W-2:0], loud};
                    if (seen_reg != '1)
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            hist_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        ovf_reg        <= ovf_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        rad_reg        <= rad_next;
        srem_reg       <= srem_next;
        root_reg       <= root_next;
        step_reg       <= step_next;
        thr2_reg       <= (2*THR_W)'(cfg.rms_threshold) * (2*THR_W)'(cfg.rms_threshold);
        prod_reg       <= PROD_W'(thr2_reg) * PROD_W'(cnt_reg);
        out_rms_reg    <= out_rms_next;
        out_loud_reg   <= out_loud_next;
        out_active_reg <= out_active_next;
        out_ovf_reg    <= out_ovf_next;
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvad_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int LONG_HOLD     = 1000;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [RMS_W-1:0] rms_level;
        logic             chunk_loud;
        logic             voice_active;
        logic             chunk_overflow;
    } verdict_t;

    typedef enum int {
        QUIET_CHUNK,
        LOUD_CHUNK,
        EDGE_CHUNK,
        NOISE_CHUNK
    } chunk_kind_t;

    class chunk_verdicts;
        verdict_t          pending[$];
        int                failures;
        logic [THR_W-1:0]  thr;
        logic [RUN_W-1:0]  run_len;
        logic [42:0]       square_sum;
        logic [12:0]       sample_count;
        logic [HIST_W-1:0] loud_history;
        logic [SEEN_W-1:0] chunks_seen;
        logic              overflow_seen;

        function new();
            failures      = 0;
            thr           = THR_RESET;
            run_len       = RUN_RESET;
            square_sum    = '0;
            sample_count  = '0;
            loud_history  = '0;
            chunks_seen   = '0;
            overflow_seen = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_RMS_THRESHOLD:     thr = value[THR_W-1:0];
                CFG_SILENT_RUN_LENGTH: run_len = value[RUN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [RMS_W-1:0] floor_root(longint unsigned v);
            logic [RMS_W-1:0] root;
            logic [RMS_W-1:0] trial;
            longint unsigned  t;
            root = '0;
            for (int k = RMS_W - 1; k >= 0; k--)
            begin
                trial = root | (RMS_W'(1) << k);
                t = 64'(trial);
                if (t * t <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void absorb_sample(logic signed [SAMPLE_W-1:0] s, logic last);
            longint            sv;
            longint unsigned   mag;
            longint unsigned   mean;
            longint unsigned   bound;
            int unsigned       window;
            logic [HIST_W-1:0] mask;
            logic              loud;
            verdict_t          v;
            sv  = longint'(s);
            mag = (sv < 0) ? -sv : sv;
            if (sample_count < MAX_CHUNK_SAMPLES_DEF)
            begin
                square_sum   = square_sum + 43'(mag * mag);
                sample_count = sample_count + 1'b1;
            end
            else
                overflow_seen = 1'b1;
            if (!last)
                return;
            mean  = (sample_count != 0) ? 64'(square_sum) / 64'(sample_count) : 64'd0;
            bound = 64'(thr);
            bound = bound * 64'(thr) * 64'(sample_count);
            loud  = (64'(square_sum) >= bound);
            if (run_len == 0)
                window = 1;
            else if (run_len > RUN_MAX)
                window = 32'(RUN_MAX);
            else
                window = 32'(run_len);
            window = window - 1;
            mask = HIST_W'((1 << window) - 1);
            v.rms_level      = floor_root(mean);
            v.chunk_loud     = loud;
            v.voice_active   = loud || (chunks_seen < window) || ((loud_history & mask) != 0);
            v.chunk_overflow = overflow_seen;
            pending = {pending, v};
            loud_history = {loud_history[HIST_W-2:0], loud};
            if (chunks_seen != '1)
                chunks_seen = chunks_seen + 1'b1;
            square_sum    = '0;
            sample_count  = '0;
            overflow_seen = 1'b0;
        endfunction

        function void compare_verdict(logic [RMS_W-1:0] rms_level, logic chunk_loud,
                                      logic voice_active, logic chunk_overflow);
            verdict_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: rms_level %0d", rms_level);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (rms_level !== want.rms_level)
            begin
                $error("rms_level: expected %0d, actual %0d", want.rms_level, rms_level);
                failures++;
            end
            if (chunk_loud !== want.chunk_loud)
            begin
                $error("chunk_loud: expected %0b, actual %0b", want.chunk_loud, chunk_loud);
                failures++;
            end
            if (voice_active !== want.voice_active)
            begin
                $error("voice_active: expected %0b, actual %0b",
                       want.voice_active, voice_active);
                failures++;
            end
            if (chunk_overflow !== want.chunk_overflow)
            begin
                $error("chunk_overflow: expected %0b, actual %0b",
                       want.chunk_overflow, chunk_overflow);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rvad_sample_if sample_bus ();
    rvad_result_if result_bus ();
    rvad_cfg_if    reg_bus ();

    rms_voice_activity_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (result_bus),
        .cfg     (reg_bus)
    );

    chunk_verdicts    verdicts;
    bit               gaps_on      = 1'b0;
    bit               stalls_on    = 1'b0;
    bit               hold_request = 1'b0;
    int unsigned      quiet_cycles = 0;
    logic [THR_W-1:0] level_threshold = THR_RESET;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_bus.valid && sample_bus.ready)
                verdicts.absorb_sample(sample_bus.sample, sample_bus.last_in_chunk);
            if (result_bus.valid && result_bus.ready)
                verdicts.compare_verdict(result_bus.rms_level, result_bus.chunk_loud,
                                         result_bus.voice_active, result_bus.chunk_overflow);
            if (reg_bus.valid && reg_bus.ready)
                verdicts.write_register(reg_bus.index, reg_bus.data);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
            || (reg_bus.valid && reg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("rms_voice_activity_detector: mismatch");
        $finish;
    end

    // hold off results at random; one long hold on request to back up the input
    initial
    begin
        result_bus.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                result_bus.ready <= 1'b1;
                hold_request = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        sample_bus.valid         <= 1'b1;
        sample_bus.sample        <= value;
        sample_bus.last_in_chunk <= last;
        do @(posedge clk); while (!sample_bus.ready);
    endtask

    task automatic wait_for_idle();
        sample_bus.valid <= 1'b0;
        while (verdicts.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [THR_W-1:0] thr, input logic [RUN_W-1:0] run);
        wait_for_idle();
        reg_bus.valid <= 1'b1;
        reg_bus.index <= CFG_RMS_THRESHOLD;
        reg_bus.data  <= CFG_DATA_W'(thr);
        do @(posedge clk); while (!reg_bus.ready);
        reg_bus.index <= CFG_SILENT_RUN_LENGTH;
        reg_bus.data  <= CFG_DATA_W'(run);
        do @(posedge clk); while (!reg_bus.ready);
        reg_bus.valid <= 1'b0;
        level_threshold = thr;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(chunk_kind_t kind);
        int lim;
        int v;
        lim = int'(level_threshold);
        case (kind)
            QUIET_CHUNK:
            begin
                lim = (level_threshold == 0) ? 0
                                             : int'($urandom_range(0, level_threshold - 1));
                v = int'($urandom_range(0, 2 * lim)) - lim;
            end
            LOUD_CHUNK:
            begin
                lim = int'($urandom_range(lim, 32768));
                v = $urandom_range(0, 1) ? -lim : lim;
            end
            EDGE_CHUNK:
            begin
                if (lim > 0 && $urandom_range(0, 1))
                    lim = lim - 1;
                v = $urandom_range(0, 1) ? -lim : lim;
            end
            default:
                v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_chunk(input chunk_kind_t kind, input int len);
        for (int i = 0; i < len; i++)
            send_sample(draw_sample(kind), i == len - 1);
    endtask

    task automatic random_phase(input int items);
        int          sent;
        int          len;
        chunk_kind_t kind;
        sent = 0;
        while (sent < items)
        begin
            kind = chunk_kind_t'($urandom_range(0, 3));
            repeat ($urandom_range(1, 10))
            begin
                len = int'(($urandom_range(0, 15) == 0) ? $urandom_range(13, 80)
                                                        : $urandom_range(1, 12));
                send_chunk(kind, len);
                sent += len;
            end
        end
    endtask

    task automatic random_settings();
        logic [THR_W-1:0] thr;
        logic [RUN_W-1:0] run;
        case ($urandom_range(0, 3))
            0: thr = THR_W'($urandom_range(0, 32768));
            1: thr = THR_W'($urandom_range(0, 300));
            2: thr = $urandom_range(0, 1) ? 16'd32768 : 16'd0;
            default: thr = THR_W'($urandom_range(2000, 12000));
        endcase
        run = ($urandom_range(0, 4) == 0) ? RUN_W'($urandom_range(0, 15))
                                          : RUN_W'($urandom_range(1, 8));
        apply_settings(thr, run);
    endtask

    initial
    begin
        verdicts = new();
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.sample = '0;
        sample_bus.last_in_chunk = 1'b0;
        reg_bus.valid = 1'b0;
        reg_bus.index = CFG_RMS_THRESHOLD;
        reg_bus.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: full scale, silence, smoothing warm-up, equality at threshold
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd4999, 1'b1);
        send_sample(16'sd5000, 1'b1);
        send_sample(16'sd4999, 1'b1);

        apply_settings(16'd0, 4'd1);
        send_sample(16'sd0, 1'b1);

        apply_settings(16'd32768, RUN_MAX);
        send_sample(-16'sd32768, 1'b1);
        repeat (8) send_sample(16'sd32767, 1'b1);

        apply_settings(16'hFFFF, 4'd0);
        send_sample(-16'sd32768, 1'b1);

        apply_settings(16'd1000, 4'd15);
        send_sample(16'sd999, 1'b1);
        send_sample(-16'sd1000, 1'b1);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int p = 0; p < 7; p++)
        begin
            random_settings();
            if (p == 3)
            begin
                gaps_on = 1'b0;
                hold_request = 1'b1;
                for (int c = 0; c < 80; c++)
                    send_chunk(chunk_kind_t'($urandom_range(0, 3)),
                               int'($urandom_range(1, 3)));
                gaps_on = 1'b1;
            end
            random_phase(PHASE_ITEMS);
        end

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_settings();
        random_phase(PHASE_ITEMS);

        wait_for_idle();
        if (verdicts.failures == 0)
            $display("rms_voice_activity_detector: match");
        else
            $display("rms_voice_activity_detector: mismatch");
        $finish;
    end
endmodule
